>>> hw/rtl/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

    // default sizing of the managed pool
    localparam int unsigned MaxOrderDef  = 6;
    localparam int unsigned PageCountDef = 1024;
    localparam int unsigned PageShiftDef = 12;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_BLOCK  = 2'd2,
        ST_BAD_ADDR  = 2'd3
    } t_status;

    typedef struct packed {
        logic        mode;
        logic [31:0] request_size;
        logic [31:0] free_address;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_address;
        logic [2:0]  block_order;
    } t_result;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_SEL,
        S_UL_RD,
        S_UL_WR,
        S_A_SPLIT,
        S_PUSH_A,
        S_PUSH_B,
        S_F_CHK,
        S_F_TAKE,
        S_F_BUD,
        S_F_BCHK,
        S_DONE
    } t_state;

    // datapath micro-operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_A_SEL,
        OP_UL_RD,
        OP_UL_WR,
        OP_A_SPLIT,
        OP_PUSH_A,
        OP_PUSH_B,
        OP_F_CHK,
        OP_F_TAKE,
        OP_F_BUD
    } t_op;

    // datapath status seen by the controller
    typedef struct packed {
        logic in_mode;
        logic mode;
        logic fits;
        logic found;
        logic addr_ok;
        logic fl_alloc;
        logic merge_try;
        logic bud_match;
        logic list_busy;
        logic split_more;
        logic clr_last;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> hw/rtl/bpa_ram.sv
`default_nettype none
module bpa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/bpa_ctrl.sv
`default_nettype none
module bpa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire bpa_pkg::t_dp_stat i_stat,
    output bpa_pkg::t_op           o_op,
    output logic                   o_busy,
    output logic                   o_valid
);

    bpa_pkg::t_state r_state;
    bpa_pkg::t_state n_state;

    // state register; reset enters the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpa_pkg::S_CLEAR:   n_state = i_stat.clr_last ? bpa_pkg::S_IDLE : bpa_pkg::S_CLEAR;
            bpa_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (i_stat.in_mode == bpa_pkg::MODE_FREE) ?
                              bpa_pkg::S_F_CHK : bpa_pkg::S_A_SEL;
                end
            end
            bpa_pkg::S_A_SEL:
                n_state = (i_stat.fits && i_stat.found) ? bpa_pkg::S_UL_RD : bpa_pkg::S_DONE;
            bpa_pkg::S_UL_RD:   n_state = bpa_pkg::S_UL_WR;
            bpa_pkg::S_UL_WR:
                n_state = (i_stat.mode == bpa_pkg::MODE_FREE) ?
                          bpa_pkg::S_F_BUD : bpa_pkg::S_A_SPLIT;
            bpa_pkg::S_A_SPLIT:
                n_state = i_stat.split_more ? bpa_pkg::S_PUSH_A : bpa_pkg::S_DONE;
            bpa_pkg::S_PUSH_A: begin
                if (i_stat.list_busy) begin
                    n_state = bpa_pkg::S_PUSH_B;
                end else begin
                    n_state = (i_stat.mode == bpa_pkg::MODE_FREE) ?
                              bpa_pkg::S_DONE : bpa_pkg::S_A_SPLIT;
                end
            end
            bpa_pkg::S_PUSH_B:
                n_state = (i_stat.mode == bpa_pkg::MODE_FREE) ?
                          bpa_pkg::S_DONE : bpa_pkg::S_A_SPLIT;
            bpa_pkg::S_F_CHK:
                n_state = i_stat.addr_ok ? bpa_pkg::S_F_TAKE : bpa_pkg::S_DONE;
            bpa_pkg::S_F_TAKE:
                n_state = i_stat.fl_alloc ? bpa_pkg::S_F_BUD : bpa_pkg::S_DONE;
            bpa_pkg::S_F_BUD:
                n_state = i_stat.merge_try ? bpa_pkg::S_F_BCHK : bpa_pkg::S_PUSH_A;
            bpa_pkg::S_F_BCHK:
                n_state = i_stat.bud_match ? bpa_pkg::S_UL_RD : bpa_pkg::S_PUSH_A;
            bpa_pkg::S_DONE:    n_state = bpa_pkg::S_IDLE;
            default:            n_state = bpa_pkg::S_IDLE;
        endcase
    end

    // outputs: datapath operation, busy and result strobe
    always_comb begin
        o_op    = bpa_pkg::OP_NONE;
        o_busy  = (r_state != bpa_pkg::S_IDLE);
        o_valid = (r_state == bpa_pkg::S_DONE);
        unique case (r_state)
            bpa_pkg::S_CLEAR:   o_op = bpa_pkg::OP_CLEAR;
            bpa_pkg::S_IDLE:    o_op = i_start ? bpa_pkg::OP_LOAD : bpa_pkg::OP_NONE;
            bpa_pkg::S_A_SEL:   o_op = bpa_pkg::OP_A_SEL;
            bpa_pkg::S_UL_RD:   o_op = bpa_pkg::OP_UL_RD;
            bpa_pkg::S_UL_WR:   o_op = bpa_pkg::OP_UL_WR;
            bpa_pkg::S_A_SPLIT: o_op = bpa_pkg::OP_A_SPLIT;
            bpa_pkg::S_PUSH_A:  o_op = bpa_pkg::OP_PUSH_A;
            bpa_pkg::S_PUSH_B:  o_op = bpa_pkg::OP_PUSH_B;
            bpa_pkg::S_F_CHK:   o_op = bpa_pkg::OP_F_CHK;
            bpa_pkg::S_F_TAKE:  o_op = bpa_pkg::OP_F_TAKE;
            bpa_pkg::S_F_BUD:   o_op = bpa_pkg::OP_F_BUD;
            default:            o_op = bpa_pkg::OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/bpa_dp.sv
`default_nettype none
module bpa_dp #(
    parameter int unsigned MAX_ORDER  = bpa_pkg::MaxOrderDef,
    parameter int unsigned PAGE_COUNT = bpa_pkg::PageCountDef,
    parameter int unsigned PAGE_SHIFT = bpa_pkg::PageShiftDef
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bpa_pkg::t_op      i_op,
    input  wire bpa_pkg::t_item    i_item,
    input  wire logic              i_cfg_we,
    input  wire logic [31:0]       i_cfg_data,
    output bpa_pkg::t_dp_stat      o_stat,
    output bpa_pkg::t_result       o_result
);

    localparam int unsigned IW    = $clog2(PAGE_COUNT);
    localparam int unsigned OS    = MAX_ORDER + 1;
    localparam int unsigned OW    = $clog2(OS);
    localparam int unsigned FW    = OW + 2;
    localparam int unsigned XW    = IW + MAX_ORDER + 1;
    localparam int unsigned BLK   = 1 << MAX_ORDER;
    localparam int unsigned NB    = PAGE_COUNT / BLK;
    localparam int unsigned HEAD0 = (NB > 0) ? (NB - 1) * BLK : 0;

    // list heads, configuration and clearing counter
    logic [31:0]   r_base;
    logic [IW-1:0] r_cnt;
    logic [IW-1:0] r_head     [OS];
    logic          r_nonempty [OS];

    // per-request working registers
    logic          r_mode;
    logic          r_fits;
    logic          r_addr_ok;
    logic [OW-1:0] r_want;
    logic [OW-1:0] r_ord;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_uidx;
    logic [IW-1:0] r_pidx;
    logic [IW-1:0] r_old;
    logic [1:0]    r_res_status;
    logic [31:0]   r_res_addr;
    logic [2:0]    r_res_ord;

    // memory ports
    logic          fl_we, nx_we, pv_we;
    logic [IW-1:0] fl_wa, nx_wa, pv_wa, fl_ra;
    logic [FW-1:0] fl_wd, fl_q;
    logic [IW-1:0] nx_wd, pv_wd, nx_q, pv_q;

    // decoded signals
    logic          want_fits;
    logic [OW-1:0] want_ord;
    logic [31:0]   off;
    logic [32:0]   off_x;
    logic          in_addr_ok;
    logic          found;
    logic [OW-1:0] src;
    logic [OW-1:0] fq_ord;
    logic          fq_free;
    logic          fq_alloc;
    logic [OW-1:0] fq_clamp;
    logic [XW-1:0] bud_x;
    logic [XW-1:0] spl_x;
    logic [OW-1:0] ord_m1;
    logic          merge_try;
    logic          split_more;
    logic          pv_head;
    logic          nx_tail;
    logic [XW-1:0] i_x;
    logic          clr_head;
    logic [XW-1:0] clr_nx;
    logic [XW-1:0] clr_pv;
    logic [31:0]   blk_addr;

    // smallest order whose block holds the requested size
    always_comb begin
        want_fits = 1'b0;
        want_ord  = '0;
        for (int k = MAX_ORDER; k >= 0; k--) begin
            if ({1'b0, i_item.request_size} <= (33'd1 << (PAGE_SHIFT + k))) begin
                want_fits = 1'b1;
                want_ord  = OW'(k);
            end
        end
    end

    // frame index of a freed address relative to the pool base
    assign off        = i_item.free_address - r_base;
    assign off_x      = {1'b0, off} >> PAGE_SHIFT;
    assign in_addr_ok = (off[PAGE_SHIFT-1:0] == '0) && (off_x < 33'(PAGE_COUNT));

    // first non-empty list at the wanted order or above
    always_comb begin
        found = 1'b0;
        src   = '0;
        for (int k = MAX_ORDER; k >= 0; k--) begin
            if (r_nonempty[k] && (OW'(k) >= r_want)) begin
                found = 1'b1;
                src   = OW'(k);
            end
        end
    end

    // flag word fields: order, free head, allocated head
    assign fq_ord   = fl_q[FW-1:2];
    assign fq_free  = fl_q[1];
    assign fq_alloc = fl_q[0];
    assign fq_clamp = (fq_ord > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : fq_ord;

    // buddy indices for merging and splitting
    assign bud_x      = XW'(r_idx) ^ (XW'(1) << r_ord);
    assign ord_m1     = r_ord - 1'b1;
    assign spl_x      = XW'(r_idx) ^ (XW'(1) << ord_m1);
    assign merge_try  = (r_ord < OW'(MAX_ORDER)) && (bud_x < XW'(PAGE_COUNT));
    assign split_more = (r_ord > r_want);

    // list neighbours of the block being unlinked
    assign pv_head = (pv_q == r_uidx);
    assign nx_tail = (nx_q == r_uidx);

    // initial contents for the clearing pass: top-order chain, highest block first
    assign i_x      = XW'(r_cnt);
    assign clr_head = ((i_x & XW'(BLK - 1)) == '0) && (i_x + XW'(BLK) <= XW'(PAGE_COUNT));
    assign clr_nx   = (clr_head && (r_cnt != '0)) ? i_x - XW'(BLK) : i_x;
    assign clr_pv   = (clr_head && (i_x + XW'(2 * BLK) <= XW'(PAGE_COUNT))) ?
                      i_x + XW'(BLK) : i_x;

    assign blk_addr = r_base + (32'(r_idx) << PAGE_SHIFT);

    // memory port selection
    always_comb begin
        fl_we = 1'b0;
        fl_wa = r_idx;
        fl_wd = '0;
        fl_ra = r_idx;
        nx_we = 1'b0;
        nx_wa = r_pidx;
        nx_wd = r_pidx;
        pv_we = 1'b0;
        pv_wa = r_pidx;
        pv_wd = r_pidx;
        unique case (i_op)
            bpa_pkg::OP_CLEAR: begin
                fl_we = 1'b1;
                fl_wa = r_cnt;
                fl_wd = clr_head ? {OW'(MAX_ORDER), 1'b1, 1'b0} : '0;
                nx_we = 1'b1;
                nx_wa = r_cnt;
                nx_wd = clr_nx[IW-1:0];
                pv_we = 1'b1;
                pv_wa = r_cnt;
                pv_wd = clr_pv[IW-1:0];
            end
            bpa_pkg::OP_UL_WR: begin
                nx_we = !pv_head;
                nx_wa = pv_q;
                nx_wd = nx_tail ? pv_q : nx_q;
                pv_we = !nx_tail;
                pv_wa = nx_q;
                pv_wd = pv_head ? nx_q : pv_q;
                if (r_mode == bpa_pkg::MODE_FREE) begin
                    fl_we = 1'b1;
                    fl_wa = r_uidx;
                    fl_wd = {r_ord, 1'b0, 1'b0};
                end
            end
            bpa_pkg::OP_A_SPLIT: begin
                if (!split_more) begin
                    fl_we = 1'b1;
                    fl_wd = {r_want, 1'b0, 1'b1};
                end
            end
            bpa_pkg::OP_PUSH_A: begin
                fl_we = 1'b1;
                fl_wa = r_pidx;
                fl_wd = {r_ord, 1'b1, 1'b0};
                nx_we = 1'b1;
                nx_wd = r_nonempty[r_ord] ? r_head[r_ord] : r_pidx;
                pv_we = 1'b1;
            end
            bpa_pkg::OP_PUSH_B: begin
                pv_we = 1'b1;
                pv_wa = r_old;
            end
            bpa_pkg::OP_F_TAKE: begin
                fl_we = fq_alloc;
                fl_wd = {fq_ord, 1'b0, 1'b0};
            end
            bpa_pkg::OP_F_BUD: begin
                fl_ra = bud_x[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    bpa_ram #(.WIDTH(FW), .DEPTH(PAGE_COUNT)) u_flags (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_wa),
        .i_wdata (fl_wd),
        .i_raddr (fl_ra),
        .o_rdata (fl_q)
    );

    bpa_ram #(.WIDTH(IW), .DEPTH(PAGE_COUNT)) u_next (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_wa),
        .i_wdata (nx_wd),
        .i_raddr (r_uidx),
        .o_rdata (nx_q)
    );

    bpa_ram #(.WIDTH(IW), .DEPTH(PAGE_COUNT)) u_prev (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_wa),
        .i_wdata (pv_wd),
        .i_raddr (r_uidx),
        .o_rdata (pv_q)
    );

    // list heads, base register and clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_cnt  <= '0;
            for (int k = 0; k < OS; k++) begin
                r_head[k]     <= (k == MAX_ORDER) ? IW'(HEAD0) : '0;
                r_nonempty[k] <= (k == MAX_ORDER) && (NB > 0);
            end
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            unique case (i_op)
                bpa_pkg::OP_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                bpa_pkg::OP_UL_WR: begin
                    if (pv_head) begin
                        if (nx_tail) begin
                            r_nonempty[r_ord] <= 1'b0;
                        end else begin
                            r_head[r_ord] <= nx_q;
                        end
                    end
                end
                bpa_pkg::OP_PUSH_A: begin
                    r_head[r_ord]     <= r_pidx;
                    r_nonempty[r_ord] <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // working registers and result
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            bpa_pkg::OP_LOAD: begin
                r_mode    <= i_item.mode;
                r_fits    <= want_fits;
                r_want    <= want_ord;
                r_addr_ok <= in_addr_ok;
                r_idx     <= off_x[IW-1:0];
            end
            bpa_pkg::OP_A_SEL: begin
                if (r_fits && found) begin
                    r_ord  <= src;
                    r_idx  <= r_head[src];
                    r_uidx <= r_head[src];
                end else begin
                    r_res_status <= r_fits ? bpa_pkg::ST_NO_BLOCK : bpa_pkg::ST_TOO_LARGE;
                    r_res_addr   <= '0;
                    r_res_ord    <= '0;
                end
            end
            bpa_pkg::OP_UL_WR: begin
                if (r_mode == bpa_pkg::MODE_FREE) begin
                    if (r_uidx < r_idx) begin
                        r_idx <= r_uidx;
                    end
                    r_ord <= r_ord + 1'b1;
                end
            end
            bpa_pkg::OP_A_SPLIT: begin
                if (split_more) begin
                    r_ord  <= ord_m1;
                    r_pidx <= spl_x[IW-1:0];
                end else begin
                    r_res_status <= bpa_pkg::ST_OK;
                    r_res_addr   <= blk_addr;
                    r_res_ord    <= 3'(r_want);
                end
            end
            bpa_pkg::OP_PUSH_A: begin
                r_old <= r_head[r_ord];
                if (r_mode == bpa_pkg::MODE_FREE) begin
                    r_res_status <= bpa_pkg::ST_OK;
                    r_res_addr   <= '0;
                    r_res_ord    <= 3'(r_ord);
                end
            end
            bpa_pkg::OP_F_CHK: begin
                if (!r_addr_ok) begin
                    r_res_status <= bpa_pkg::ST_BAD_ADDR;
                    r_res_addr   <= '0;
                    r_res_ord    <= '0;
                end
            end
            bpa_pkg::OP_F_TAKE: begin
                if (fq_alloc) begin
                    r_ord <= fq_clamp;
                end else begin
                    r_res_status <= bpa_pkg::ST_BAD_ADDR;
                    r_res_addr   <= '0;
                    r_res_ord    <= '0;
                end
            end
            bpa_pkg::OP_F_BUD: begin
                r_uidx <= bud_x[IW-1:0];
                r_pidx <= r_idx;
            end
            default: begin
            end
        endcase
    end

    // status towards the controller
    always_comb begin
        o_stat.in_mode    = i_item.mode;
        o_stat.mode       = r_mode;
        o_stat.fits       = r_fits;
        o_stat.found      = found;
        o_stat.addr_ok    = r_addr_ok;
        o_stat.fl_alloc   = fq_alloc;
        o_stat.merge_try  = merge_try;
        o_stat.bud_match  = fq_free && (fq_ord == r_ord);
        o_stat.list_busy  = r_nonempty[r_ord];
        o_stat.split_more = split_more;
        o_stat.clr_last   = (r_cnt == IW'(PAGE_COUNT - 1));
    end

    assign o_result.status        = r_res_status;
    assign o_result.block_address = r_res_addr;
    assign o_result.block_order   = r_res_ord;

endmodule
`default_nettype wire

>>> hw/rtl/buddy_page_allocator.sv
`default_nettype none
// Buddy page allocator. An item is taken when start is high and busy is low; its one result
// appears on o_result for a single cycle with o_valid high and must be captured then, as the
// block cannot be held off. After reset the block runs a clearing pass (busy high) that lays out
// the frame table; the base register may be written meanwhile. Timing is set by one shared
// frame table with a single write and registered read port per field. An allocate selects
// the smallest non-empty list at or above the wanted order, unlinks its head block and splits
// it down, pushing each upper half onto its list; an oversize request or an empty pool ends at
// the selection. A free checks the address and the allocated flag, then merges with each free
// buddy of equal order in turn before pushing the merged block; a bad address ends at a check.
// The next item may be accepted in the cycle right after the result.
module buddy_page_allocator #(
    parameter int unsigned MAX_ORDER  = bpa_pkg::MaxOrderDef,
    parameter int unsigned PAGE_COUNT = bpa_pkg::PageCountDef,
    parameter int unsigned PAGE_SHIFT = bpa_pkg::PageShiftDef
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire bpa_pkg::t_item   i_item,
    input  wire logic             i_cfg_we,
    input  wire logic [31:0]      i_cfg_data,
    output logic                  o_valid,
    output bpa_pkg::t_result      o_result
);

    bpa_pkg::t_op      op;
    bpa_pkg::t_dp_stat stat;

    // sequencing
    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_op    (op),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // frame table, lists and result
    bpa_dp #(
        .MAX_ORDER  (MAX_ORDER),
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_result   (o_result)
    );

endmodule
`default_nettype wire

>>> hw/rtl/bpa_check.sv
`default_nettype none
module bpa_check (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_valid,
    input wire bpa_pkg::t_result o_result
);

    // a result lasts one cycle only
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // a result is shown only while an item is in work
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    // errors carry zero address and order
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status != bpa_pkg::ST_OK)) |->
            ((o_result.block_address == '0) && (o_result.block_order == '0)))
        else $error("error result with non-zero address or order");

endmodule

bind buddy_page_allocator bpa_check u_bpa_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
`default_nettype wire

>>> tb/sv/buddy_page_allocator_test.sv
`default_nettype none
module buddy_page_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TOP_ORDER  = bpa_pkg::MaxOrderDef;
    localparam int unsigned FRAMES     = bpa_pkg::PageCountDef;
    localparam int unsigned FRAME_BITS = bpa_pkg::PageShiftDef;
    localparam int unsigned TOP_BLOCKS = FRAMES >> TOP_ORDER;
    localparam int unsigned STALL_LIMIT = 6000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    bpa_pkg::t_item   i_item = '0;
    logic             i_cfg_we = 1'b0;
    logic [31:0]      i_cfg_data = '0;
    logic             o_valid;
    bpa_pkg::t_result o_result;

    buddy_page_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    always #6 i_clk = ~i_clk;

    // shadow allocator state
    logic [31:0] pool_base;
    logic [2:0]  order_of   [FRAMES];
    logic        free_head  [FRAMES];
    logic        alloc_head [FRAMES];
    int unsigned next_link  [FRAMES];
    int unsigned prev_link  [FRAMES];
    int unsigned head_frame [TOP_ORDER + 1];
    logic        list_used  [TOP_ORDER + 1];
    int unsigned live_blocks[$];

    bpa_pkg::t_result pending_results[$];
    int          error_count = 0;
    int          stall_cycles = 0;
    bit          no_gaps = 0;

    function automatic void list_push(int unsigned idx, int unsigned ord);
        if (list_used[ord]) begin
            next_link[idx] = head_frame[ord];
            prev_link[head_frame[ord]] = idx;
        end else begin
            next_link[idx] = idx;
        end
        prev_link[idx] = idx;
        head_frame[ord] = idx;
        list_used[ord] = 1'b1;
    endfunction

    function automatic void list_unlink(int unsigned idx, int unsigned ord);
        int unsigned nx;
        int unsigned pv;
        nx = next_link[idx];
        pv = prev_link[idx];
        if (pv == idx) begin
            if (nx == idx) begin
                list_used[ord] = 1'b0;
            end else begin
                head_frame[ord] = nx;
                prev_link[nx] = nx;
            end
        end else begin
            next_link[pv] = (nx == idx) ? pv : nx;
            if (nx != idx) prev_link[nx] = pv;
        end
        next_link[idx] = idx;
        prev_link[idx] = idx;
    endfunction

    function automatic void reset_allocator();
        pool_base = '0;
        live_blocks.delete();
        for (int i = 0; i <= TOP_ORDER; i++) begin
            head_frame[i] = 0;
            list_used[i] = 1'b0;
        end
        for (int i = 0; i < FRAMES; i++) begin
            order_of[i] = '0;
            free_head[i] = 1'b0;
            alloc_head[i] = 1'b0;
            next_link[i] = i;
            prev_link[i] = i;
        end
        for (int i = 0; i < TOP_BLOCKS; i++) begin
            order_of[i << TOP_ORDER] = 3'(TOP_ORDER);
            free_head[i << TOP_ORDER] = 1'b1;
            list_push(i << TOP_ORDER, TOP_ORDER);
        end
    endfunction

    // work out the result of one item and advance the shadow state
    function automatic bpa_pkg::t_result allocate_or_free(bpa_pkg::t_item it);
        bpa_pkg::t_result r;
        int unsigned want;
        int unsigned src;
        int unsigned idx;
        int unsigned bud;
        int unsigned ord;
        logic [31:0] off;
        bit          fits;
        r = '0;
        r.status = bpa_pkg::ST_OK;
        if (it.mode == bpa_pkg::MODE_ALLOC) begin
            fits = 0;
            for (want = 0; want <= TOP_ORDER; want++) begin
                if (64'(it.request_size) <= (64'd1 << (FRAME_BITS + want))) begin
                    fits = 1;
                    break;
                end
            end
            if (!fits) begin
                r.status = bpa_pkg::ST_TOO_LARGE;
            end else begin
                for (src = want; src <= TOP_ORDER; src++)
                    if (list_used[src]) break;
                if (src > TOP_ORDER) begin
                    r.status = bpa_pkg::ST_NO_BLOCK;
                end else begin
                    idx = head_frame[src];
                    list_unlink(idx, src);
                    free_head[idx] = 1'b0;
                    while (src > want) begin
                        src--;
                        bud = idx ^ (1 << src);
                        order_of[bud] = 3'(src);
                        free_head[bud] = 1'b1;
                        alloc_head[bud] = 1'b0;
                        list_push(bud, src);
                    end
                    order_of[idx] = 3'(want);
                    alloc_head[idx] = 1'b1;
                    live_blocks.push_back(idx);
                    r.block_order = 3'(want);
                    r.block_address = pool_base + (32'(idx) << FRAME_BITS);
                end
            end
        end else begin
            off = it.free_address - pool_base;
            if (off[FRAME_BITS-1:0] != 0 || (off >> FRAME_BITS) >= FRAMES ||
                !alloc_head[off >> FRAME_BITS]) begin
                r.status = bpa_pkg::ST_BAD_ADDR;
            end else begin
                idx = off >> FRAME_BITS;
                alloc_head[idx] = 1'b0;
                foreach (live_blocks[k])
                    if (live_blocks[k] == idx) begin
                        live_blocks.delete(k);
                        break;
                    end
                ord = order_of[idx];
                while (ord < TOP_ORDER) begin
                    bud = idx ^ (1 << ord);
                    if (bud >= FRAMES || !free_head[bud] || order_of[bud] != ord) break;
                    list_unlink(bud, ord);
                    free_head[bud] = 1'b0;
                    if (bud < idx) idx = bud;
                    ord++;
                end
                order_of[idx] = 3'(ord);
                free_head[idx] = 1'b1;
                list_push(idx, ord);
                r.block_order = 3'(ord);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch in %s: expected %h, got %h at %0t", what, want, got, $realtime);
        error_count++;
    endtask

    // hold start across back-to-back items; lower it only for a gap
    task automatic send_item(bpa_pkg::t_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(allocate_or_free(it));
    endtask

    task automatic send_alloc(logic [31:0] size);
        bpa_pkg::t_item it;
        it.mode = bpa_pkg::MODE_ALLOC;
        it.request_size = size;
        it.free_address = $urandom;
        send_item(it);
    endtask

    task automatic send_free(logic [31:0] addr);
        bpa_pkg::t_item it;
        it.mode = bpa_pkg::MODE_FREE;
        it.request_size = $urandom;
        it.free_address = addr;
        send_item(it);
    endtask

    // wait until every expected result has come back
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_base(logic [31:0] base);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pool_base = base;
    endtask

    function automatic logic [31:0] frame_address(int unsigned idx);
        return pool_base + (32'(idx) << FRAME_BITS);
    endfunction

    task automatic test_size_edges();
        send_alloc(32'd0);
        send_alloc(32'd1);
        send_alloc(32'd4096);
        send_alloc(32'd4097);
        send_alloc(32'd262144);
        send_alloc(32'd262145);
        send_alloc(32'hFFFF_FFFF);
        send_alloc(32'h8000_0000);
        drain();
    endtask

    task automatic test_bad_frees();
        int unsigned idx;
        send_alloc(32'd8192);
        drain();
        idx = live_blocks[live_blocks.size() - 1];
        send_free(frame_address(idx) + 32'd1);
        send_free(frame_address(FRAMES));
        send_free(frame_address(idx + 1));
        send_free(32'hFFFF_FFFF);
        send_free(frame_address(idx));
        send_free(frame_address(idx));
        drain();
        while (live_blocks.size() != 0) send_free(frame_address(live_blocks[0]));
        drain();
    endtask

    task automatic test_pool_exhaustion();
        for (int i = 0; i <= TOP_BLOCKS; i++) send_alloc(32'd262144);
        send_alloc(32'd0);
        drain();
        while (live_blocks.size() != 0)
            send_free(frame_address(live_blocks[$urandom_range(0, live_blocks.size() - 1)]));
        drain();
    endtask

    task automatic test_random_traffic(int count);
        int unsigned ord;
        int unsigned pick;
        logic [31:0] size;
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 55 || (pick < 80 && live_blocks.size() == 0)) begin
                ord = $urandom_range(0, TOP_ORDER);
                if ($urandom_range(0, 15) == 0) size = $urandom;
                else if (ord == 0) size = $urandom_range(0, 4096);
                else size = $urandom_range((1 << (FRAME_BITS + ord - 1)) + 1,
                                           1 << (FRAME_BITS + ord));
                send_alloc(size);
            end else if (pick < 88 && live_blocks.size() != 0) begin
                send_free(frame_address(live_blocks[$urandom_range(0, live_blocks.size() - 1)]));
            end else begin
                case ($urandom_range(0, 2))
                    0: send_free($urandom);
                    1: send_free(frame_address($urandom_range(0, FRAMES + 3)));
                    default: send_free(frame_address($urandom_range(0, FRAMES - 1)) +
                                       $urandom_range(1, 4095));
                endcase
            end
        end
        no_gaps = 0;
    endtask

    task automatic test_base_settings();
        write_base(32'hFFFF_F000);
        test_random_traffic(150);
        write_base(32'hFFFF_FFFF);
        test_random_traffic(60);
        write_base($urandom & 32'hFFFF_F000);
        test_random_traffic(150);
        write_base(32'h0000_0000);
        test_random_traffic(200);
    endtask

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        bpa_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, o_result.block_address);
            end else begin
                want = pending_results.pop_front();
                if (o_result.status != want.status)
                    report_mismatch("status", want.status, o_result.status);
                if (o_result.block_address != want.block_address)
                    report_mismatch("block_address", want.block_address,
                                    o_result.block_address);
                if (o_result.block_order != want.block_order)
                    report_mismatch("block_order", want.block_order, o_result.block_order);
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (o_valid || (start && !busy)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        reset_allocator();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_size_edges();
        test_bad_frees();
        test_pool_exhaustion();
        test_base_settings();
        drain();
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
